/* src/tcte_pkg.sv */
// Shared types and constants for the template code-tag extractor.
// Depends on nothing; every other file of the block uses it.

package tcte_pkg;

    // Template characters that steer the scan
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;

    // Result and queue sizing
    localparam int LINE_OUT_W  = 24;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    // Scan mode, one-hot
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'b001,
        MODE_OUT   = 3'b010,
        MODE_EXEC  = 3'b100
    } t_mode;

    typedef enum logic {
        KIND_CODE = 1'b0,
        KIND_LINE = 1'b1
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             code_byte;
        logic [LINE_OUT_W-1:0]  line_number;
        logic                   from_output_tag;
    } t_result;

    // All results caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_packet;

    // Front to queue
    typedef struct packed {
        logic    push;
        t_packet pkt;
    } t_qwr;

    // Queue to back
    typedef struct packed {
        logic    avail;
        t_packet pkt;
    } t_qrd;

endpackage

/* src/tcte_if.sv */
// Valid/ready channel interfaces for the template code-tag extractor.
// Depends on tcte_pkg for the line-number width.

interface tcte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tcte_out_if;
    logic                             valid;
    logic                             ready;
    logic                             result_kind;
    logic [7:0]                       code_byte;
    logic [tcte_pkg::LINE_OUT_W-1:0]  line_number;
    logic                             from_output_tag;
    logic                             last;

    modport source (output valid, output result_kind, output code_byte,
                     output line_number, output from_output_tag, output last,
                     input ready);
    modport sink   (input valid, input result_kind, input code_byte,
                     input line_number, input from_output_tag, input last,
                     output ready);
endinterface

/* src/tcte_front.sv */
// Front end: look-ahead window, scan mode and line counter; classifies each
// item and builds the packet of its results. Depends on tcte_pkg, tcte_if.

module tcte_front import tcte_pkg::*; #(
    parameter int LINE_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcte_in_if.sink    i_in,
    input  logic       i_q_ready,
    output t_qwr       o_qwr
);

    typedef struct packed {
        logic [2:0][7:0]      win;
        logic [1:0]           fill;
        t_mode                mode;
        logic [LINE_BITS-1:0] line;
    } t_scan;

    typedef struct packed {
        t_scan          st;
        logic [1:0]     n;
        t_result [1:0]  res;
    } t_dec;

    localparam t_scan SCAN_RESET = '{
        win:  '0,
        fill: 2'd0,
        mode: MODE_PLAIN,
        line: LINE_BITS'(1)
    };

    function automatic t_result make_code(input logic [7:0] byte_val);
        t_result r;
        r                 = '0;
        r.kind            = KIND_CODE;
        r.code_byte       = byte_val;
        return r;
    endfunction

    function automatic t_result make_line(input logic [LINE_BITS-1:0] line,
                                          input logic flag);
        t_result r;
        r                 = '0;
        r.kind            = KIND_LINE;
        r.line_number     = LINE_OUT_W'(line);
        r.from_output_tag = flag;
        return r;
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] l);
        return (l == '1) ? l : l + 1'b1;
    endfunction

    // Decide the byte at the head of the window
    function automatic t_dec decide(input t_scan s);
        t_dec       d;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       has2;
        logic       has3;
        logic       flag;
        logic [1:0] drop;
        d      = '0;
        d.st   = s;
        a      = s.win[0];
        b      = s.win[1];
        c      = s.win[2];
        has2   = (s.fill >= 2'd2);
        has3   = (s.fill == 2'd3);
        flag   = (s.mode == MODE_OUT);
        drop   = 2'd1;
        if (s.mode == MODE_OUT || s.mode == MODE_EXEC) begin
            if (has2 && a == CH_PCT && b == CH_GT) begin
                drop = 2'd2;
            end else if (has3 && a == CH_DASH && b == CH_PCT && c == CH_GT) begin
                drop = 2'd3;
            end
            if (drop != 2'd1) begin
                // Close the tag with a newline and its line record
                d.res[0]  = make_code(CH_NL);
                d.res[1]  = make_line(s.line, flag);
                d.n       = 2'd2;
                d.st.mode = MODE_PLAIN;
            end else begin
                d.res[0] = make_code(a);
                d.n      = 2'd1;
                if (a == CH_NL) begin
                    d.res[1]  = make_line(s.line, flag);
                    d.n       = 2'd2;
                    d.st.line = sat_inc(s.line);
                end
            end
        end else begin
            if (has2 && a == CH_LT && b == CH_PCT && has3 &&
                (c == CH_EQ || c == CH_DASH)) begin
                d.st.mode = MODE_OUT;
                drop      = 2'd3;
            end else if (has2 && a == CH_LT && b == CH_PCT &&
                         !(has3 && c == CH_HASH)) begin
                d.st.mode = MODE_EXEC;
                drop      = 2'd2;
            end else if (a == CH_NL) begin
                d.st.line = sat_inc(s.line);
            end
        end
        // Shift the window
        if (drop > s.fill) begin
            drop = s.fill;
        end
        case (drop)
            2'd1:    d.st.win = {8'h00, s.win[2], s.win[1]};
            2'd2:    d.st.win = {16'h0000, s.win[2]};
            2'd3:    d.st.win = '0;
            default: d.st.win = s.win;
        endcase
        d.st.fill = s.fill - drop;
        return d;
    endfunction

    t_scan            r_scan;
    t_scan            n_scan;
    t_scan            s_in;
    t_dec             dec1;
    t_dec             dec2;
    logic [1:0]       n1;
    logic [1:0]       n2;
    logic [CNT_W-1:0] cnt;
    t_packet          pkt;
    logic             accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid & i_in.ready;

    // Classify the item and collect its results
    always_comb begin
        s_in   = r_scan;
        n_scan = r_scan;
        n1     = 2'd0;
        n2     = 2'd0;
        dec2   = '0;
        if (!i_in.end_of_input) begin
            s_in.win[r_scan.fill] = i_in.in_byte;
            s_in.fill             = r_scan.fill + 2'd1;
            dec1                  = decide(s_in);
            if (s_in.fill == 2'd3) begin
                n_scan = dec1.st;
                n1     = dec1.n;
            end else begin
                n_scan = s_in;
            end
        end else begin
            // Flush the window, then return to the reset state
            dec1 = decide(r_scan);
            dec2 = decide(dec1.st);
            if (r_scan.fill != 2'd0) begin
                n1 = dec1.n;
                if (dec1.st.fill != 2'd0) begin
                    n2 = dec2.n;
                end
            end
            n_scan = SCAN_RESET;
        end

        pkt = '0;
        cnt = '0;
        for (int j = 0; j < 2; j++) begin
            if (2'(j) < n1) begin
                pkt.res[cnt[IDX_W-1:0]] = dec1.res[j];
                cnt = cnt + 1'b1;
            end
        end
        for (int j = 0; j < 2; j++) begin
            if (2'(j) < n2) begin
                pkt.res[cnt[IDX_W-1:0]] = dec2.res[j];
                cnt = cnt + 1'b1;
            end
        end
        pkt.count = cnt;
    end

    assign o_qwr.push = accept && (cnt != '0);
    assign o_qwr.pkt  = pkt;

    // Advance the scan state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (accept) begin
            r_scan <= n_scan;
        end
    end

endmodule

/* src/tcte_queue.sv */
// Short packet queue between front and back end.
// Depends on tcte_pkg.

module tcte_queue import tcte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_qwr i_qwr,
    output logic o_q_ready,
    output t_qrd o_qrd,
    input  logic i_pop
);

    t_packet            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_q_ready   = (r_count != (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_qrd.avail = (r_count != '0);
    assign o_qrd.pkt   = r_mem[r_rd_ptr];
    assign do_push     = i_qwr.push && o_q_ready;
    assign do_pop      = i_pop && o_qrd.avail;

    // Store packets
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_qwr.pkt;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/tcte_back.sv */
// Back end: walks the results of the head packet one item per cycle while the
// output is ready, and marks the final one. Depends on tcte_pkg, tcte_if.

module tcte_back import tcte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qrd        i_qrd,
    output logic        o_pop,
    tcte_out_if.source  o_out
);

    logic [IDX_W-1:0] r_idx;
    t_result          cur;
    logic             is_last;
    logic             fire;

    assign cur     = i_qrd.pkt.res[r_idx];
    assign is_last = (CNT_W'(r_idx) == (i_qrd.pkt.count - CNT_W'(1)));
    assign fire    = o_out.valid & o_out.ready;
    assign o_pop   = fire & is_last;

    assign o_out.valid           = i_qrd.avail;
    assign o_out.result_kind     = cur.kind;
    assign o_out.code_byte       = cur.code_byte;
    assign o_out.line_number     = cur.line_number;
    assign o_out.from_output_tag = cur.from_output_tag;
    assign o_out.last            = is_last;

    // Step through the packet, back to the start after its final item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= is_last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

/* src/template_code_tag_extractor.sv */
// Template code-tag extractor, top level.
// An accepted item's results enter the queue as one packet, read at its head.
// Throughput: one item per cycle while items yield at most one result and the
// output is ready; the output port sets the rate, one result per cycle; items
// with more results (up to four on a flush) wait in a four-packet queue.
// Reset: synchronous active low; clears window, mode, line count and queue.

module template_code_tag_extractor import tcte_pkg::*; #(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcte_in_if.sink     i_in,
    tcte_out_if.source  o_out
);

    t_qwr qwr;
    t_qrd qrd;
    logic q_ready;
    logic pop;

    // Classify items
    tcte_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_qwr     (qwr)
    );

    // Decouple front from back
    tcte_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qwr     (qwr),
        .o_q_ready (q_ready),
        .o_qrd     (qrd),
        .i_pop     (pop)
    );

    // Emit results
    tcte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qrd   (qrd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
